[hdl/dbh_pkg.sv]
package dbh_pkg;

	// Field widths.
	localparam int STAMP_W  = 32;
	localparam int CNT_W    = 32;
	localparam int PCT_W    = 7;
	localparam int SCALED_W = 40;
	localparam int OUT_W    = 80;

	// Serial step counts of each phase.
	localparam int ACC_STEPS = STAMP_W;
	localparam int MUL_STEPS = SCALED_W;
	localparam int DIV_STEPS = SCALED_W;
	localparam int STEP_W    = 6;

	// Queue depth and percentage ceiling.
	localparam logic [1:0]       QUEUE_DEPTH = 2'd2;
	localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;

	// Event commands.
	typedef enum logic [1:0] {
		CMD_COMMIT  = 2'd0,
		CMD_CONSUME = 2'd1,
		CMD_QUERY   = 2'd2,
		CMD_RESTART = 2'd3
	} cmd_t;

	// Controls of the window accounting unit.
	typedef struct packed {
		logic load;
		logic acc_step;
		logic count_free;
		logic drain_step;
		logic clear;
	} acct_ctl_t;

	// Controls of a serial event counter.
	typedef struct packed {
		logic start;
		logic step;
	} ctr_ctl_t;

	// Controls of the percentage unit.
	typedef struct packed {
		logic load;
		logic mul_step;
		logic div_step;
	} pct_ctl_t;

endpackage

[hdl/dbh_acct.sv]
module dbh_acct (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dbh_pkg::acct_ctl_t          ctl,
	input  logic [dbh_pkg::STAMP_W-1:0] now,
	output logic [dbh_pkg::STAMP_W-1:0] total,
	output logic                        free_bit,
	output logic                        half_bit
);

	logic [dbh_pkg::STAMP_W-1:0] now_q;
	logic [dbh_pkg::STAMP_W-1:0] stamp_q;
	logic [dbh_pkg::STAMP_W-1:0] total_q;
	logic [dbh_pkg::STAMP_W-1:0] free_q;
	logic                        borrow_q;
	logic                        ct_q;
	logic                        cf_q;

	logic       elapsed_bit;
	logic       borrow_nxt;
	logic [1:0] total_sum;
	logic [1:0] free_sum;

	// One bit of the elapsed time and of both window sums per cycle, LSB first.
	always_comb begin
		elapsed_bit = now_q[0] ^ stamp_q[0] ^ borrow_q;
		borrow_nxt  = (~now_q[0] & stamp_q[0]) | (~now_q[0] & borrow_q) |
			(stamp_q[0] & borrow_q);
		total_sum   = 2'(total_q[0]) + 2'(elapsed_bit) + 2'(ct_q);
		if (ctl.count_free) begin
			free_sum = 2'(free_q[0]) + 2'(elapsed_bit) + 2'(cf_q);
		end else begin
			free_sum = {1'b0, free_q[0]};
		end
	end

	// The timestamp of the event rotates into the stamp register as it is used.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			now_q <= now;
		end else if (ctl.acc_step) begin
			now_q <= {1'b0, now_q[dbh_pkg::STAMP_W-1:1]};
		end
	end

	// Window registers and serial carries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stamp_q  <= '0;
			total_q  <= '0;
			free_q   <= '0;
			borrow_q <= 1'b0;
			ct_q     <= 1'b0;
			cf_q     <= 1'b0;
		end else if (ctl.load) begin
			borrow_q <= 1'b0;
			ct_q     <= 1'b0;
			cf_q     <= 1'b0;
		end else if (ctl.clear) begin
			total_q <= '0;
			free_q  <= '0;
		end else if (ctl.acc_step) begin
			stamp_q  <= {now_q[0], stamp_q[dbh_pkg::STAMP_W-1:1]};
			total_q  <= {total_sum[0], total_q[dbh_pkg::STAMP_W-1:1]};
			free_q   <= {free_sum[0], free_q[dbh_pkg::STAMP_W-1:1]};
			borrow_q <= borrow_nxt;
			ct_q     <= total_sum[1];
			cf_q     <= free_sum[1];
		end else if (ctl.drain_step) begin
			// Both sums shift out toward the scaler and are left empty.
			total_q <= {1'b0, total_q[dbh_pkg::STAMP_W-1:1]};
			free_q  <= {1'b0, free_q[dbh_pkg::STAMP_W-1:1]};
		end
	end

	assign total    = total_q;
	assign free_bit = free_q[0];
	assign half_bit = total_q[1];

endmodule

[hdl/dbh_ctr.sv]
module dbh_ctr (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dbh_pkg::ctr_ctl_t         ctl,
	input  logic                      inc,
	output logic [dbh_pkg::CNT_W-1:0] count
);

	logic [dbh_pkg::CNT_W-1:0] cnt_q;
	logic                      carry_q;

	// Serial increment: the count rotates once per event with a one-bit carry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			carry_q <= 1'b0;
		end else if (ctl.start) begin
			carry_q <= inc;
		end else if (ctl.step) begin
			cnt_q   <= {cnt_q[0] ^ carry_q, cnt_q[dbh_pkg::CNT_W-1:1]};
			carry_q <= cnt_q[0] & carry_q;
		end
	end

	assign count = cnt_q;

endmodule

[hdl/dbh_pct.sv]
module dbh_pct (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dbh_pkg::pct_ctl_t           ctl,
	input  logic [dbh_pkg::STAMP_W-1:0] divisor,
	input  logic                        free_bit,
	input  logic                        half_bit,
	output logic [dbh_pkg::PCT_W-1:0]   percent,
	output logic                        zero_div
);

	logic [dbh_pkg::SCALED_W-1:0] num_q;
	logic [dbh_pkg::STAMP_W-1:0]  div_q;
	logic [dbh_pkg::STAMP_W-1:0]  rem_q;
	logic [dbh_pkg::PCT_W-1:0]    quo_q;
	logic                         ovf_q;
	logic [5:0]                   dl_q;
	logic [2:0]                   mc_q;

	logic [3:0]                   sum;
	logic [dbh_pkg::STAMP_W:0]    trial;
	logic [dbh_pkg::STAMP_W+1:0]  diff;
	logic                         ge;

	// Scaling: free * 100 + total / 2, with 100 = 64 + 32 + 4, one bit per cycle.
	// Division: restoring, one quotient bit per cycle.
	always_comb begin
		sum   = 4'(dl_q[1]) + 4'(dl_q[4]) + 4'(dl_q[5]) + 4'(half_bit) + 4'(mc_q);
		trial = {rem_q, num_q[dbh_pkg::SCALED_W-1]};
		diff  = {1'b0, trial} - {2'b00, div_q};
		ge    = ~diff[dbh_pkg::STAMP_W+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
			div_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
			dl_q  <= '0;
			mc_q  <= '0;
		end else if (ctl.load) begin
			div_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
			ovf_q <= 1'b0;
			dl_q  <= '0;
			mc_q  <= '0;
		end else if (ctl.mul_step) begin
			num_q <= {sum[0], num_q[dbh_pkg::SCALED_W-1:1]};
			dl_q  <= {dl_q[4:0], free_bit};
			mc_q  <= sum[3:1];
		end else if (ctl.div_step) begin
			num_q <= {num_q[dbh_pkg::SCALED_W-2:0], 1'b0};
			rem_q <= ge ? diff[dbh_pkg::STAMP_W-1:0] : trial[dbh_pkg::STAMP_W-1:0];
			quo_q <= {quo_q[dbh_pkg::PCT_W-2:0], ge};
			// Any quotient bit above the kept ones means far past the ceiling.
			ovf_q <= ovf_q | quo_q[dbh_pkg::PCT_W-1];
		end
	end

	// Clamp to the ceiling.
	assign percent  = (ovf_q || (quo_q > dbh_pkg::PCT_MAX)) ? dbh_pkg::PCT_MAX : quo_q;
	assign zero_div = (div_q == '0);

endmodule

[hdl/double_buffer_handoff_monitor.sv]
// Ping-pong slot handoff between a renderer and a playback engine, with a
// monitor of how much of the time the two-entry slot queue had room.
// Input channel s_axis: one transaction is one event, the command in s_axis_tuser
// and the 32-bit event timestamp in s_axis_tdata. Output channel m_axis: one
// transaction per event with the handoff result and the running totals.
// Each event first adds its elapsed time to the window one bit per cycle; a
// query then scales the free time by 100 bit-serially and divides one quotient
// bit per cycle. A commit, consume or restart goes from the window update
// straight to the result, a query through the scaling and the division first.
// The next event is taken once the result is registered, so the block works
// on one event at a time.
// The output register holds a finished result while m_axis_tready is low; the
// block keeps working on the next event and only waits at the end of it if
// the previous result has still not been taken.
// Reset clears the queue, the window, the held percentage and both running
// totals; the block is ready as soon as reset is released.
module double_buffer_handoff_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [31:0] now
	input  logic [31:0] s_axis_tdata,
	// [1:0] cmd
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] commit_accepted, [1] play_slot, [2] underrun, [3] render_slot_now,
	// [5:4] free_slots, [12:6] free_percent, [44:13] underrun_total,
	// [76:45] commit_total, [79:77] zero
	output logic [79:0] m_axis_tdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACC,
		ST_PLOAD,
		ST_MUL,
		ST_DIV,
		ST_FIN
	} state_t;

	state_t                      state_q;
	logic [dbh_pkg::STEP_W-1:0]  step_q;
	dbh_pkg::cmd_t               cmd_q;
	logic [1:0]                  slot_q;
	logic                        head_q;
	logic                        tail_q;
	logic [1:0]                  qcount_q;
	logic                        render_q;
	logic                        last_played_q;
	logic [dbh_pkg::PCT_W-1:0]   held_q;
	logic                        out_valid_q;
	logic [dbh_pkg::OUT_W-1:0]   out_data_q;

	dbh_pkg::cmd_t               in_cmd;
	logic                        accept;
	logic                        fin_fire;
	dbh_pkg::acct_ctl_t          acct_ctl;
	dbh_pkg::ctr_ctl_t           ctr_ctl;
	dbh_pkg::pct_ctl_t           pct_ctl;
	logic [dbh_pkg::STAMP_W-1:0] win_total;
	logic                        free_bit;
	logic                        half_bit;
	logic [dbh_pkg::PCT_W-1:0]   pct_value;
	logic                        zero_div;
	logic [dbh_pkg::CNT_W-1:0]   underrun_total;
	logic [dbh_pkg::CNT_W-1:0]   commit_total;

	logic [1:0]                  slot_nxt;
	logic                        head_nxt;
	logic                        tail_nxt;
	logic [1:0]                  qcount_nxt;
	logic                        render_nxt;
	logic                        last_played_nxt;
	logic [dbh_pkg::PCT_W-1:0]   held_nxt;
	logic                        accepted;
	logic                        play;
	logic                        under;
	logic [1:0]                  free_slots;

	// Handshakes and unit controls.
	always_comb begin
		in_cmd   = dbh_pkg::cmd_t'(s_axis_tuser);
		accept   = s_axis_tvalid && (state_q == ST_IDLE);
		fin_fire = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

		acct_ctl.load       = accept;
		acct_ctl.acc_step   = (state_q == ST_ACC);
		acct_ctl.count_free = (qcount_q != dbh_pkg::QUEUE_DEPTH);
		acct_ctl.drain_step = (state_q == ST_MUL);
		acct_ctl.clear      = fin_fire && (cmd_q == dbh_pkg::CMD_RESTART);

		ctr_ctl.start = accept;
		ctr_ctl.step  = (state_q == ST_ACC);

		pct_ctl.load     = (state_q == ST_PLOAD);
		pct_ctl.mul_step = (state_q == ST_MUL);
		pct_ctl.div_step = (state_q == ST_DIV);
	end

	dbh_acct u_acct (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (acct_ctl),
		.now      (s_axis_tdata),
		.total    (win_total),
		.free_bit (free_bit),
		.half_bit (half_bit)
	);

	dbh_ctr u_commit_ctr (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctr_ctl),
		.inc    (in_cmd == dbh_pkg::CMD_COMMIT),
		.count  (commit_total)
	);

	dbh_ctr u_underrun_ctr (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctr_ctl),
		.inc    ((in_cmd == dbh_pkg::CMD_CONSUME) && (qcount_q == 2'd0)),
		.count  (underrun_total)
	);

	dbh_pct u_pct (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (pct_ctl),
		.divisor  (win_total),
		.free_bit (free_bit),
		.half_bit (half_bit),
		.percent  (pct_value),
		.zero_div (zero_div)
	);

	// Queue update and result of the event.
	always_comb begin
		slot_nxt        = slot_q;
		head_nxt        = head_q;
		tail_nxt        = tail_q;
		qcount_nxt      = qcount_q;
		render_nxt      = render_q;
		last_played_nxt = last_played_q;
		held_nxt        = held_q;
		accepted        = 1'b0;
		play            = 1'b0;
		under           = 1'b0;
		case (cmd_q)
			dbh_pkg::CMD_COMMIT: begin
				if (qcount_q != dbh_pkg::QUEUE_DEPTH) begin
					slot_nxt[tail_q] = render_q;
					tail_nxt         = ~tail_q;
					render_nxt       = ~render_q;
					qcount_nxt       = qcount_q + 2'd1;
					accepted         = 1'b1;
				end
			end
			dbh_pkg::CMD_CONSUME: begin
				if (qcount_q != 2'd0) begin
					play       = slot_q[head_q];
					head_nxt   = ~head_q;
					qcount_nxt = qcount_q - 2'd1;
				end else begin
					play  = last_played_q;
					under = 1'b1;
				end
				last_played_nxt = play;
			end
			dbh_pkg::CMD_QUERY: begin
				// An empty window keeps the previous answer.
				if (!zero_div) begin
					held_nxt = pct_value;
				end
			end
			dbh_pkg::CMD_RESTART: begin
				slot_nxt        = '0;
				head_nxt        = 1'b0;
				tail_nxt        = 1'b0;
				qcount_nxt      = 2'd0;
				render_nxt      = 1'b0;
				last_played_nxt = 1'b0;
				held_nxt        = '0;
			end
			default: begin
			end
		endcase
		free_slots = dbh_pkg::QUEUE_DEPTH - qcount_nxt;
	end

	// Sequencer, queue state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= '0;
			cmd_q         <= dbh_pkg::CMD_COMMIT;
			slot_q        <= '0;
			head_q        <= 1'b0;
			tail_q        <= 1'b0;
			qcount_q      <= 2'd0;
			render_q      <= 1'b0;
			last_played_q <= 1'b0;
			held_q        <= '0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			// A new result takes the output register as the old one leaves.
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cmd_q   <= in_cmd;
						step_q  <= '0;
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (step_q == dbh_pkg::STEP_W'(dbh_pkg::ACC_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= (cmd_q == dbh_pkg::CMD_QUERY) ? ST_PLOAD : ST_FIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_PLOAD: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (step_q == dbh_pkg::STEP_W'(dbh_pkg::MUL_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DIV: begin
					if (step_q == dbh_pkg::STEP_W'(dbh_pkg::DIV_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (fin_fire) begin
						slot_q        <= slot_nxt;
						head_q        <= head_nxt;
						tail_q        <= tail_nxt;
						qcount_q      <= qcount_nxt;
						render_q      <= render_nxt;
						last_played_q <= last_played_nxt;
						held_q        <= held_nxt;
						out_data_q    <= {3'b000, commit_total, underrun_total, held_nxt,
							free_slots, render_nxt, under, play, accepted};
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

`ifndef SYNTH
	// An accepted event keeps the input closed in the following cycle.
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while an event is in progress");

	// A reported free slot count never exceeds the queue depth.
	a_free_slots: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[5:4] <= dbh_pkg::QUEUE_DEPTH))
		else $error("free slot count out of range");

	// A reported percentage is clamped to the ceiling.
	a_percent: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[12:6] <= dbh_pkg::PCT_MAX))
		else $error("free percentage above ceiling");

	// A new result is only loaded when the previous one has left.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready && (state_q == ST_FIN)) |=> (state_q == ST_FIN))
		else $error("result overwritten while stalled");
`endif

endmodule
